>>> src/gcpe_pkg.sv
// Shared types, constants and helpers for the glyph cell pixel expander.
package gcpe_pkg;

	localparam int MAX_CELL_WIDTH  = 64;
	localparam int MAX_CELL_HEIGHT = 64;

	localparam int COORD_W = 14;
	localparam int DIM_W   = 7;
	localparam int COLOR_W = 24;
	localparam int BYTE_W  = 8;
	localparam int PIX_W   = $clog2(BYTE_W);

	// Command queue between front and back; depth must be a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int CFG_INDEX_W = 2;
	typedef logic [CFG_INDEX_W-1:0] reg_index_t;
	localparam reg_index_t REG_FG_COLOR    = 2'd0;
	localparam reg_index_t REG_BG_COLOR    = 2'd1;
	localparam reg_index_t REG_CELL_HEIGHT = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0]  glyph_byte;
		logic               first_byte;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [DIM_W-1:0]   cell_width;
		logic               underline;
	} in_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               last;
	} out_item_t;

	// One classified byte: where its run of pixels starts and how long it is.
	typedef struct packed {
		logic [BYTE_W-1:0]  glyph_byte;
		logic [COORD_W-1:0] base_x;
		logic [COORD_W-1:0] pixel_y;
		logic [PIX_W-1:0]   count_m1;
		logic               force_fg;
	} cmd_t;

	// Zero acts as one, anything past the limit acts as the limit.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
		logic [DIM_W+1:0] m;
		m = (DIM_W+2)'(maxv);
		if (v == '0)
			return DIM_W'(1);
		if ({2'b00, v} > m)
			return DIM_W'(maxv);
		return v;
	endfunction

endpackage

>>> src/gcpe_front.sv
// Front end: accepts bitmap bytes, tracks column and row, classifies each byte into a command.
module gcpe_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  gcpe_pkg::in_item_t                in_data,
	input  logic [gcpe_pkg::DIM_W-1:0]        cell_height,
	input  logic                              q_full,
	output logic                              push,
	output gcpe_pkg::cmd_t                    cmd
);

	logic [gcpe_pkg::DIM_W-1:0] col_q, row_q;
	logic [gcpe_pkg::DIM_W-1:0] col_start, row_start;
	logic [gcpe_pkg::DIM_W-1:0] width, height, ul_row, diff;
	logic                       past_end, fits, ends_row;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		col_start = in_data.first_byte ? '0 : col_q;
		row_start = in_data.first_byte ? '0 : row_q;
		width     = gcpe_pkg::clamp_dim(in_data.cell_width, gcpe_pkg::MAX_CELL_WIDTH);
		height    = gcpe_pkg::clamp_dim(cell_height, gcpe_pkg::MAX_CELL_HEIGHT);
		ul_row    = height - gcpe_pkg::DIM_W'(1);
		// column already at or past the width: one pixel, then the row ends
		past_end  = col_start >= width;
		diff      = width - col_start;
		fits      = diff <= gcpe_pkg::DIM_W'(gcpe_pkg::BYTE_W);
		ends_row  = past_end || fits;

		cmd.glyph_byte = in_data.glyph_byte;
		cmd.base_x     = in_data.cell_x + gcpe_pkg::COORD_W'(col_start);
		cmd.pixel_y    = in_data.cell_y + gcpe_pkg::COORD_W'(row_start);
		cmd.force_fg   = in_data.underline && (row_start == ul_row);
		if (past_end)
			cmd.count_m1 = '0;
		else if (fits)
			cmd.count_m1 = gcpe_pkg::PIX_W'(diff - gcpe_pkg::DIM_W'(1));
		else
			cmd.count_m1 = gcpe_pkg::PIX_W'(gcpe_pkg::BYTE_W - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (ends_row) begin
				col_q <= '0;
				row_q <= row_start + gcpe_pkg::DIM_W'(1);
			end else begin
				col_q <= col_start + gcpe_pkg::DIM_W'(gcpe_pkg::BYTE_W);
				row_q <= row_start;
			end
		end
	end

endmodule

>>> src/gcpe_queue.sv
// Short command queue that decouples the front end from the pixel back end.
module gcpe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gcpe_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           pop,
	output gcpe_pkg::cmd_t rd_data,
	output logic           empty
);

	gcpe_pkg::cmd_t                  mem_q [gcpe_pkg::QUEUE_DEPTH];
	logic [gcpe_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [gcpe_pkg::QPTR_W:0]       count_q;

	assign full    = count_q == (gcpe_pkg::QPTR_W+1)'(gcpe_pkg::QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + gcpe_pkg::QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + gcpe_pkg::QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (gcpe_pkg::QPTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (gcpe_pkg::QPTR_W+1)'(1);
		end
	end

endmodule

>>> src/gcpe_back.sv
// Back end: walks the head command one pixel per cycle into the output register while the output is not stalled.
module gcpe_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  gcpe_pkg::cmd_t                head,
	output logic                          pop,
	input  logic [gcpe_pkg::COLOR_W-1:0]  fg_color,
	input  logic [gcpe_pkg::COLOR_W-1:0]  bg_color,
	output logic                          out_valid,
	input  logic                          out_stall,
	output gcpe_pkg::out_item_t           out_data
);

	logic                        out_valid_q;
	gcpe_pkg::out_item_t         out_q, pixel;
	logic [gcpe_pkg::PIX_W-1:0]  k_q;
	logic                        load, take, is_last, bit_set;

	assign load      = !out_valid_q || !out_stall;
	assign take      = load && !empty;
	assign is_last   = k_q == head.count_m1;
	assign pop       = take && is_last;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		// bit 7 is the leftmost pixel
		bit_set           = head.glyph_byte[gcpe_pkg::PIX_W'(gcpe_pkg::BYTE_W - 1) - k_q];
		pixel.pixel_x     = head.base_x + gcpe_pkg::COORD_W'(k_q);
		pixel.pixel_y     = head.pixel_y;
		pixel.pixel_color = (bit_set || head.force_fg) ? fg_color : bg_color;
		pixel.last        = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (load)
				out_valid_q <= !empty;
			if (take)
				k_q <= is_last ? '0 : k_q + gcpe_pkg::PIX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			out_q <= pixel;
	end

endmodule

>>> src/glyph_cell_pixel_expander.sv
// Top level of the glyph cell pixel expander: configuration registers and front/queue/back.
//
//   channel   direction  handshake          beat
//   in        input      in_valid/in_stall  one bitmap byte with cell position and width
//   out       output     out_valid/out_stall one colored pixel, last on the byte's final pixel
//   cfg       input      cfg_write          one register write (fg, bg, cell height)
//
// Each byte yields 1 to 8 pixels, one pixel per cycle from the back end while the output
// is not stalled.
// The front end classifies a byte in the cycle it is accepted and queues it (2 entries);
// the back end's output register reloads in the cycle its beat is taken.
// Reset clears the column and row counters, the queue and the output valid.
// A stall on the output holds the pixel; the input stalls only while the queue is full.
module glyph_cell_pixel_expander (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  gcpe_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output gcpe_pkg::out_item_t                 out_data,
	input  logic                                cfg_write,
	input  gcpe_pkg::reg_index_t                cfg_index,
	input  logic [gcpe_pkg::COLOR_W-1:0]        cfg_data
);

	logic [gcpe_pkg::COLOR_W-1:0] fg_color_q, bg_color_q;
	logic [gcpe_pkg::DIM_W-1:0]   cell_height_q;
	logic                         q_full, q_empty, push, pop;
	gcpe_pkg::cmd_t               cmd_in, cmd_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q    <= '1;
			bg_color_q    <= '0;
			cell_height_q <= gcpe_pkg::DIM_W'(16);
		end else if (cfg_write) begin
			case (cfg_index)
				gcpe_pkg::REG_FG_COLOR:    fg_color_q    <= cfg_data;
				gcpe_pkg::REG_BG_COLOR:    bg_color_q    <= cfg_data;
				gcpe_pkg::REG_CELL_HEIGHT: cell_height_q <= cfg_data[gcpe_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	gcpe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.cell_height (cell_height_q),
		.q_full      (q_full),
		.push        (push),
		.cmd         (cmd_in)
	);

	gcpe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (cmd_in),
		.full    (q_full),
		.pop     (pop),
		.rd_data (cmd_head),
		.empty   (q_empty)
	);

	gcpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (cmd_head),
		.pop       (pop),
		.fg_color  (fg_color_q),
		.bg_color  (bg_color_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> src/gcpe_checker.sv
// Port-level checks for the glyph cell pixel expander, bound to the top level.
module gcpe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input gcpe_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("output beat changed while stalled");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last |=> out_valid)
		else $error("pixel run broken before its last beat");

	a_run_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last |=>
		out_data.pixel_x == gcpe_pkg::COORD_W'($past(out_data.pixel_x) + 1'b1) &&
		out_data.pixel_y == $past(out_data.pixel_y))
		else $error("pixel run does not advance by one column");

endmodule

bind glyph_cell_pixel_expander gcpe_checker u_gcpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> tb/tb_glyph_cell_pixel_expander.sv
// Testbench for the glyph cell pixel expander: directed table, random glyph streams, pixel checks.
`timescale 1ns / 1ps

module tb_glyph_cell_pixel_expander;

	localparam int LONG_HOLD   = 300;
	localparam int WDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 24;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                          kind;
		gcpe_pkg::reg_index_t               idx;
		logic [gcpe_pkg::COLOR_W-1:0]       val;
		gcpe_pkg::in_item_t                 item;
		bit                                 has_exp;
		gcpe_pkg::out_item_t                exp_px;
	} dir_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	gcpe_pkg::in_item_t                  in_data;
	logic                                out_valid;
	logic                                out_stall;
	gcpe_pkg::out_item_t                 out_data;
	logic                                cfg_write;
	gcpe_pkg::reg_index_t                cfg_index;
	logic [gcpe_pkg::COLOR_W-1:0]        cfg_data;

	// mirror of the block's registers and counters
	logic [gcpe_pkg::COLOR_W-1:0]        fg_reg;
	logic [gcpe_pkg::COLOR_W-1:0]        bg_reg;
	logic [gcpe_pkg::DIM_W-1:0]          height_reg;
	logic [gcpe_pkg::DIM_W-1:0]          col_cnt;
	logic [gcpe_pkg::DIM_W-1:0]          row_cnt;

	gcpe_pkg::out_item_t                 pending_pixels[$];
	dir_row_t                            dir_tab[$];

	int  bytes_sent;
	int  pixels_seen;
	int  reg_writes;
	int  errors;
	int  quiet_cycles;
	bit  idling;
	bit  long_hold_req;

	glyph_cell_pixel_expander u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int dim_eff(input logic [gcpe_pkg::DIM_W-1:0] v, input int maxv);
		if (v == '0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	// Expand one accepted byte into its pixels and queue them.
	task automatic expand_byte(input gcpe_pkg::in_item_t it, output int n);
		int                          w;
		int                          h;
		logic [gcpe_pkg::DIM_W-1:0]  ul_row;
		bit                          fgpix;
		bit                          row_end;
		gcpe_pkg::out_item_t         px;
		w = dim_eff(it.cell_width, gcpe_pkg::MAX_CELL_WIDTH);
		h = dim_eff(height_reg, gcpe_pkg::MAX_CELL_HEIGHT);
		ul_row = gcpe_pkg::DIM_W'(h - 1);
		n = 0;
		if (it.first_byte) begin
			col_cnt = '0;
			row_cnt = '0;
		end
		for (int b = 7; b >= 0; b--) begin
			fgpix = it.glyph_byte[b] || (it.underline && row_cnt == ul_row);
			row_end = (int'(col_cnt) + 1) >= w;
			px.pixel_x = it.cell_x + gcpe_pkg::COORD_W'(col_cnt);
			px.pixel_y = it.cell_y + gcpe_pkg::COORD_W'(row_cnt);
			px.pixel_color = fgpix ? fg_reg : bg_reg;
			px.last = row_end || b == 0;
			pending_pixels = {pending_pixels, px};
			n++;
			if (row_end) begin
				col_cnt = '0;
				row_cnt = row_cnt + 1'b1;
				break;
			end
			col_cnt = col_cnt + 1'b1;
		end
	endtask

	// Offer one beat, hold it through stalls, predict on acceptance.
	task automatic send_byte(input gcpe_pkg::in_item_t it, output int n);
		int gap;
		gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data = it;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		expand_byte(it, n);
		bytes_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input gcpe_pkg::reg_index_t idx,
			input logic [gcpe_pkg::COLOR_W-1:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		case (idx)
			gcpe_pkg::REG_FG_COLOR:    fg_reg = val;
			gcpe_pkg::REG_BG_COLOR:    bg_reg = val;
			gcpe_pkg::REG_CELL_HEIGHT: height_reg = val[gcpe_pkg::DIM_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	function automatic void add_row(input dir_row_t r);
		dir_tab = {dir_tab, r};
	endfunction

	function automatic dir_row_t row_cfg(input gcpe_pkg::reg_index_t idx,
			input logic [gcpe_pkg::COLOR_W-1:0] val);
		dir_row_t r;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.val = val;
		r.item = '0;
		r.has_exp = 1'b0;
		r.exp_px = '0;
		return r;
	endfunction

	function automatic dir_row_t row_byte(input logic [7:0] gb, input logic fb,
			input logic [gcpe_pkg::COORD_W-1:0] cx, input logic [gcpe_pkg::COORD_W-1:0] cy,
			input logic [gcpe_pkg::DIM_W-1:0] w, input logic ul, input bit has_exp,
			input logic [gcpe_pkg::COORD_W-1:0] ex, input logic [gcpe_pkg::COORD_W-1:0] ey,
			input logic [gcpe_pkg::COLOR_W-1:0] ec, input logic el);
		dir_row_t r;
		r.kind = ROW_BYTE;
		r.idx = gcpe_pkg::REG_FG_COLOR;
		r.val = '0;
		r.item = '{glyph_byte: gb, first_byte: fb, cell_x: cx, cell_y: cy,
			cell_width: w, underline: ul};
		r.has_exp = has_exp;
		r.exp_px = '{pixel_x: ex, pixel_y: ey, pixel_color: ec, last: el};
		return r;
	endfunction

	function automatic logic [gcpe_pkg::COORD_W-1:0] rand_coord();
		if ($urandom_range(0, 3) == 0)
			return gcpe_pkg::COORD_W'(16383 - $urandom_range(0, 63));
		return gcpe_pkg::COORD_W'($urandom);
	endfunction

	// One glyph of padded rows; a broken one may draw a new width partway through.
	task automatic send_glyph(input bit broken);
		int                          r;
		int                          weff;
		int                          bpr;
		int                          rows;
		int                          total;
		int                          cut;
		int                          n;
		logic [gcpe_pkg::DIM_W-1:0]  wf;
		gcpe_pkg::in_item_t          it;
		r = $urandom_range(0, 9);
		if (r < 7)
			wf = gcpe_pkg::DIM_W'($urandom_range(1, 16));
		else if (r < 9)
			wf = gcpe_pkg::DIM_W'($urandom_range(17, 64));
		else if ($urandom_range(0, 1) == 0)
			wf = '0;
		else
			wf = gcpe_pkg::DIM_W'($urandom_range(65, 127));
		weff = dim_eff(wf, gcpe_pkg::MAX_CELL_WIDTH);
		bpr = (weff + 7) / 8;
		rows = $urandom_range(1, dim_eff(height_reg, gcpe_pkg::MAX_CELL_HEIGHT) + 1);
		while (rows * bpr > 24 && rows > 1)
			rows--;
		total = rows * bpr;
		cut = broken ? $urandom_range(1, total) : total + 1;
		it.cell_x = rand_coord();
		it.cell_y = rand_coord();
		it.underline = $urandom_range(0, 2) != 0;
		for (int k = 0; k < total; k++) begin
			if (k == cut)
				wf = gcpe_pkg::DIM_W'($urandom_range(0, 127));
			it.glyph_byte = 8'($urandom);
			it.first_byte = (k == 0);
			it.cell_width = wf;
			send_byte(it, n);
		end
	endtask

	task automatic run_until(input int target);
		int                  kind;
		int                  n;
		logic [63:0]         raw;
		gcpe_pkg::in_item_t  it;
		while (bytes_sent < target) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				send_glyph(1'b0);
			end else if (kind < 9) begin
				raw = {$urandom, $urandom};
				it = raw[$bits(gcpe_pkg::in_item_t)-1:0];
				send_byte(it, n);
			end else begin
				send_glyph(1'b1);
			end
		end
	endtask

	// Pixel checker: every taken beat must match the oldest expectation.
	always @(posedge clk) begin
		gcpe_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel x=%0d y=%0d color=%06h last=%0b",
					out_data.pixel_x, out_data.pixel_y, out_data.pixel_color, out_data.last);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (out_data.pixel_x !== want.pixel_x) begin
					$error("pixel_x: expected %0d, got %0d", want.pixel_x, out_data.pixel_x);
					errors++;
				end
				if (out_data.pixel_y !== want.pixel_y) begin
					$error("pixel_y: expected %0d, got %0d", want.pixel_y, out_data.pixel_y);
					errors++;
				end
				if (out_data.pixel_color !== want.pixel_color) begin
					$error("pixel_color: expected %06h, got %06h",
						want.pixel_color, out_data.pixel_color);
					errors++;
				end
				if (out_data.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, out_data.last);
					errors++;
				end
			end
		end
	end

	// Watchdog: too many cycles without any beat ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin
		int burst_left;
		out_stall = 1'b0;
		burst_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
				out_stall = 1'b0;
			end else if (burst_left > 0) begin
				out_stall = 1'b1;
				burst_left--;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 16) - 1;
				out_stall = 1'b1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		int                            n;
		int                            first_idx;
		logic [gcpe_pkg::COORD_W-1:0]  wx;
		logic [gcpe_pkg::COORD_W-1:0]  wy;
		gcpe_pkg::in_item_t            it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_write = 1'b0;
		cfg_index = gcpe_pkg::REG_FG_COLOR;
		cfg_data = '0;
		idling = 1'b0;
		long_hold_req = 1'b0;
		bytes_sent = 0;
		pixels_seen = 0;
		reg_writes = 0;
		errors = 0;
		quiet_cycles = 0;
		fg_reg = 24'hFFFFFF;
		bg_reg = '0;
		height_reg = 7'd16;
		col_cnt = '0;
		row_cnt = '0;

		// reset values, extremes, zero and oversize widths and heights,
		// width change mid-glyph, underline rows in and past the cell
		add_row(row_byte(8'h80, 1, 0, 0, 8, 0, 1, 0, 0, 24'hFFFFFF, 0));
		add_row(row_byte(8'h00, 0, 0, 0, 8, 0, 1, 0, 1, 24'h000000, 0));
		add_row(row_byte(8'hFF, 1, 16383, 16383, 64, 1, 1,
			16383, 16383, 24'hFFFFFF, 0));
		add_row(row_byte(8'h5A, 0, 16383, 16383, 64, 1, 0, 0, 0, 0, 0));
		add_row(row_byte(8'h00, 1, 100, 200, 0, 0, 1, 100, 200, 24'h000000, 1));
		add_row(row_byte(8'h00, 0, 100, 200, 0, 0, 0, 0, 0, 0, 0));
		add_row(row_byte(8'hA5, 1, 5, 9, 127, 0, 0, 0, 0, 0, 0));
		add_row(row_byte(8'h3C, 1, 1000, 50, 20, 0, 0, 0, 0, 0, 0));
		add_row(row_byte(8'h0F, 0, 1000, 50, 20, 0, 0, 0, 0, 0, 0));
		add_row(row_byte(8'hF0, 0, 1000, 50, 4, 0, 1, 1016, 50, 24'hFFFFFF, 1));
		add_row(row_byte(8'hC3, 0, 1000, 50, 4, 0, 0, 0, 0, 0, 0));
		add_row(row_cfg(gcpe_pkg::REG_CELL_HEIGHT, 24'd0));
		add_row(row_byte(8'h00, 1, 0, 0, 8, 1, 1, 0, 0, 24'hFFFFFF, 0));
		add_row(row_cfg(gcpe_pkg::REG_FG_COLOR, 24'h000000));
		add_row(row_cfg(gcpe_pkg::REG_BG_COLOR, 24'hFFFFFF));
		add_row(row_byte(8'h00, 1, 7, 7, 3, 0, 1, 7, 7, 24'hFFFFFF, 0));
		add_row(row_byte(8'hFF, 0, 7, 7, 3, 0, 1, 7, 8, 24'h000000, 0));
		add_row(row_cfg(gcpe_pkg::REG_CELL_HEIGHT, 24'd2));
		add_row(row_cfg(gcpe_pkg::REG_FG_COLOR, 24'h0000FF));
		add_row(row_cfg(gcpe_pkg::REG_BG_COLOR, 24'hFF0000));
		add_row(row_byte(8'h00, 1, 300, 400, 1, 1, 1, 300, 400, 24'hFF0000, 1));
		add_row(row_byte(8'h00, 0, 300, 400, 1, 1, 1, 300, 401, 24'h0000FF, 1));
		add_row(row_byte(8'h00, 0, 300, 400, 1, 1, 0, 0, 0, 0, 0));
		add_row(row_byte(8'h00, 0, 300, 400, 1, 0, 0, 0, 0, 0, 0));
		add_row(row_cfg(gcpe_pkg::REG_CELL_HEIGHT, 24'd127));
		add_row(row_cfg(gcpe_pkg::REG_FG_COLOR, 24'h00FF00));
		add_row(row_byte(8'h81, 1, 16380, 16383, 64, 1, 0, 0, 0, 0, 0));
		add_row(row_byte(8'hFF, 1, 0, 0, 1, 0, 1, 0, 0, 24'h00FF00, 1));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				send_byte(dir_tab[i].item, n);
				// a typed-in first pixel takes the place of the predicted one
				if (dir_tab[i].has_exp) begin
					first_idx = pending_pixels.size() - n;
					pending_pixels[first_idx] = dir_tab[i].exp_px;
				end
			end
		end

		// random glyphs with idling on both sides
		wait_drained();
		write_reg(gcpe_pkg::REG_FG_COLOR, 24'($urandom));
		write_reg(gcpe_pkg::REG_BG_COLOR, 24'($urandom));
		write_reg(gcpe_pkg::REG_CELL_HEIGHT, 24'($urandom_range(1, 8)));
		idling = 1'b1;
		run_until(50);

		// long receiver hold while the sender keeps offering beats
		wait_drained();
		write_reg(gcpe_pkg::REG_CELL_HEIGHT, 24'd64);
		idling = 1'b0;
		long_hold_req = 1'b1;
		run_until(bytes_sent + 16);

		// one tall glyph of single-pixel rows: underline row, rows past the cell,
		// row counter wrap
		wait_drained();
		write_reg(gcpe_pkg::REG_CELL_HEIGHT, 24'd127);
		write_reg(gcpe_pkg::REG_FG_COLOR, 24'($urandom));
		idling = 1'b1;
		wx = rand_coord();
		wy = rand_coord();
		for (int k = 0; k < 132; k++) begin
			it.glyph_byte = 8'($urandom);
			it.first_byte = (k == 0);
			it.cell_x = wx;
			it.cell_y = wy;
			it.cell_width = gcpe_pkg::DIM_W'($urandom_range(0, 1));
			it.underline = 1'b1;
			send_byte(it, n);
		end

		// extreme colors, one-row cells, no idling
		wait_drained();
		write_reg(gcpe_pkg::REG_FG_COLOR, 24'h000000);
		write_reg(gcpe_pkg::REG_BG_COLOR, 24'hFFFFFF);
		write_reg(gcpe_pkg::REG_CELL_HEIGHT, 24'd1);
		idling = 1'b0;
		run_until(bytes_sent + 30);

		// random phase with idling, then the final stretch without it
		wait_drained();
		write_reg(gcpe_pkg::REG_FG_COLOR, 24'($urandom));
		write_reg(gcpe_pkg::REG_BG_COLOR, 24'($urandom));
		write_reg(gcpe_pkg::REG_CELL_HEIGHT, 24'($urandom_range(0, 127)));
		idling = 1'b1;
		run_until(bytes_sent + 15);
		idling = 1'b0;
		run_until(bytes_sent + 25);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d glyph bytes, %0d pixels and %0d register writes.",
			bytes_sent, pixels_seen, reg_writes);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
